/* rtl/core/ftrq_pkg.sv */
`default_nettype none

package ftrq_pkg;

  // Scheduler size. Task numbers in the item are four bits wide whatever
  // the table size; numbers at or above TASK_TOTAL are treated as absent.
  localparam int TASK_TOTAL = 16;
  localparam int MAIN_TASK  = 0;
  localparam int MAIN_IDX   = (MAIN_TASK < TASK_TOTAL) ? MAIN_TASK : 0;

  localparam int ID_W  = 4;
  localparam int IDX_W = (TASK_TOTAL > 1) ? $clog2(TASK_TOTAL) : 1;
  localparam int CNT_W = $clog2(TASK_TOTAL + 1);
  localparam int CMP_W = ((IDX_W > ID_W) ? IDX_W : ID_W) + 1;

  typedef enum logic [1:0] {
    OP_CREATE   = 2'd0,
    OP_SCHEDULE = 2'd1,
    OP_YIELD    = 2'd2,
    OP_QUERY    = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    ST_STOPPED   = 2'd0,
    ST_SCHEDULED = 2'd1,
    ST_RUNNING   = 2'd2
  } status_t;

  typedef struct packed {
    op_t             op;
    logic [ID_W-1:0] task_id;
  } request_t;

  typedef struct packed {
    logic [1:0]      task_state;
    logic [ID_W-1:0] running_task;
    logic            running_valid;
    logic            switched;
    logic            rejected;
  } result_t;

  // Commands from the sequencer to the datapath.
  typedef struct packed {
    logic load;
    logic stop;
    logic push;
    logic pop;
    logic dispatch;
    logic set_wait;
    logic capture;
    logic switched;
    logic rejected;
  } ftrq_cmd_t;

  // Status from the datapath to the sequencer.
  typedef struct packed {
    op_t  op;
    logic in_range;
    logic sched_hit;
    logic full;
    logic empty;
    logic waiting;
  } ftrq_stat_t;

endpackage

`default_nettype wire

/* rtl/core/ftrq_ram.sv */
`default_nettype none

module ftrq_ram #(
  parameter int WIDTH = 4,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     wr_en,
  input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]         wr_data,
  input  wire logic                     rd_en,
  input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
  output      logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

`default_nettype wire

/* rtl/core/ftrq_datapath.sv */
`default_nettype none

module ftrq_datapath (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire ftrq_pkg::request_t  request,
  input  wire ftrq_pkg::ftrq_cmd_t cmd,
  output      ftrq_pkg::ftrq_stat_t stat,
  output      ftrq_pkg::result_t   result
);

  localparam int IDX_W = ftrq_pkg::IDX_W;
  localparam int CNT_W = ftrq_pkg::CNT_W;
  localparam int ID_W  = ftrq_pkg::ID_W;
  localparam int CMP_W = ftrq_pkg::CMP_W;

  ftrq_pkg::status_t  status [ftrq_pkg::TASK_TOTAL];
  ftrq_pkg::op_t      op;
  logic [ID_W-1:0]    task_id;
  logic [IDX_W-1:0]   current;
  logic               waiting;
  logic [IDX_W-1:0]   head;
  logic [IDX_W-1:0]   tail;
  logic [CNT_W-1:0]   count;

  logic               in_range;
  logic [IDX_W-1:0]   id_idx;
  logic [IDX_W-1:0]   sel;
  ftrq_pkg::status_t  sel_status;
  logic [IDX_W-1:0]   popped;
  logic [1:0]         state_now;

  assign in_range   = {{(CMP_W-ID_W){1'b0}}, task_id} < CMP_W'(ftrq_pkg::TASK_TOTAL);
  assign id_idx     = IDX_W'(task_id);
  // A yield looks at the running task, every other op at the named one.
  assign sel        = (op == ftrq_pkg::OP_YIELD) ? current : id_idx;
  assign sel_status = status[sel];

  assign stat.op        = op;
  assign stat.in_range  = in_range;
  assign stat.sched_hit = (sel_status == ftrq_pkg::ST_SCHEDULED);
  assign stat.full      = (count == CNT_W'(ftrq_pkg::TASK_TOTAL));
  assign stat.empty     = (count == '0);
  assign stat.waiting   = waiting;

  ftrq_ram #(
    .WIDTH (IDX_W),
    .DEPTH (ftrq_pkg::TASK_TOTAL)
  ) u_slots (
    .clk     (clk),
    .wr_en   (cmd.push),
    .wr_addr (tail),
    .wr_data (id_idx),
    .rd_en   (cmd.pop),
    .rd_addr (head),
    .rd_data (popped)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < ftrq_pkg::TASK_TOTAL; i++) begin
        status[i] <= (i == ftrq_pkg::MAIN_IDX) ? ftrq_pkg::ST_RUNNING : ftrq_pkg::ST_STOPPED;
      end
    end else begin
      priority if (cmd.dispatch) begin
        status[popped] <= ftrq_pkg::ST_RUNNING;
      end else if (cmd.push) begin
        status[sel] <= ftrq_pkg::ST_SCHEDULED;
      end else if (cmd.stop) begin
        status[sel] <= ftrq_pkg::ST_STOPPED;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      current <= IDX_W'(ftrq_pkg::MAIN_IDX);
      waiting <= 1'b0;
      head    <= '0;
      tail    <= '0;
      count   <= '0;
    end else begin
      if (cmd.push) begin
        tail <= (tail == IDX_W'(ftrq_pkg::TASK_TOTAL - 1)) ? '0 : tail + 1'b1;
      end
      if (cmd.pop) begin
        head <= (head == IDX_W'(ftrq_pkg::TASK_TOTAL - 1)) ? '0 : head + 1'b1;
      end
      if (cmd.push && !cmd.pop) begin
        count <= count + 1'b1;
      end else if (cmd.pop && !cmd.push) begin
        count <= count - 1'b1;
      end
      if (cmd.dispatch) begin
        current <= popped;
        waiting <= 1'b0;
      end else if (cmd.set_wait) begin
        waiting <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op      <= request.op;
      task_id <= request.task_id;
    end
  end

  always_comb begin
    state_now = ftrq_pkg::ST_STOPPED;
    if (op == ftrq_pkg::OP_YIELD) begin
      if (!waiting) begin
        state_now = sel_status;
      end
    end else if (in_range) begin
      state_now = sel_status;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      result.task_state    <= state_now;
      result.running_task  <= waiting ? '0 : ID_W'(current);
      result.running_valid <= !waiting;
      result.switched      <= cmd.switched;
      result.rejected      <= cmd.rejected;
    end
  end

`ifndef SYNTH
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_W'(ftrq_pkg::TASK_TOTAL))
    else $error("ready queue count above capacity");

  // A task scheduled while waiting sits in the queue only until it is read out.
  a_wait_empty: assert property (@(posedge clk) disable iff (rst)
    (waiting && !cmd.pop) |-> count == '0)
    else $error("waiting for work with tasks queued");

  a_ring_ends: assert property (@(posedge clk) disable iff (rst)
    (head == tail) |-> (count == '0 || count == CNT_W'(ftrq_pkg::TASK_TOTAL)))
    else $error("ring pointers disagree with queue count");
`endif

endmodule

`default_nettype wire

/* rtl/core/ftrq_ctrl.sv */
`default_nettype none

module ftrq_ctrl (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 start,
  input  wire ftrq_pkg::ftrq_stat_t stat,
  output      ftrq_pkg::ftrq_cmd_t  cmd,
  output      logic                 busy,
  output      logic                 done
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_CHECK,
    S_POP,
    S_DISPATCH,
    S_REPORT
  } state_t;

  state_t state;
  state_t state_next;
  logic   switched;
  logic   rejected;
  logic   refuse;

  assign busy   = (state != S_IDLE);
  assign refuse = stat.in_range && (stat.sched_hit || stat.full);

  always_comb begin
    cmd          = '0;
    cmd.switched = switched;
    cmd.rejected = rejected;
    state_next   = state;
    unique case (state)
      S_IDLE: begin
        if (start) begin
          cmd.load   = 1'b1;
          state_next = S_CHECK;
        end
      end
      S_CHECK: begin
        state_next = S_REPORT;
        unique case (stat.op)
          ftrq_pkg::OP_CREATE: begin
            cmd.stop = stat.in_range && !stat.sched_hit;
          end
          ftrq_pkg::OP_SCHEDULE: begin
            if (stat.in_range && !refuse) begin
              cmd.push = 1'b1;
              if (stat.waiting) begin
                state_next = S_POP;
              end
            end
          end
          ftrq_pkg::OP_YIELD: begin
            if (!stat.waiting) begin
              cmd.stop = !stat.sched_hit;
              if (!stat.empty) begin
                state_next = S_POP;
              end else begin
                cmd.set_wait = 1'b1;
              end
            end
          end
          ftrq_pkg::OP_QUERY: begin
          end
          default: begin
          end
        endcase
      end
      S_POP: begin
        cmd.pop    = 1'b1;
        state_next = S_DISPATCH;
      end
      S_DISPATCH: begin
        cmd.dispatch = 1'b1;
        state_next   = S_REPORT;
      end
      S_REPORT: begin
        cmd.capture = 1'b1;
        state_next  = S_IDLE;
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      switched <= 1'b0;
      rejected <= 1'b0;
      done     <= 1'b0;
    end else begin
      state <= state_next;
      done  <= (state == S_REPORT);
      if (cmd.load) begin
        switched <= 1'b0;
        rejected <= 1'b0;
      end else if (state == S_CHECK) begin
        rejected <= (stat.op == ftrq_pkg::OP_SCHEDULE) && refuse;
        switched <= (state_next == S_POP);
      end
    end
  end

`ifndef SYNTH
  a_done_after_report: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(state == S_REPORT))
    else $error("result strobe without a report step");

  a_pop_then_dispatch: assert property (@(posedge clk) disable iff (rst)
    cmd.pop |=> cmd.dispatch)
    else $error("queue read not followed by dispatch");

  a_busy_after_start: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> busy)
    else $error("accepted item did not make the block busy");
`endif

endmodule

`default_nettype wire

/* rtl/core/fifo_task_ready_queue.sv */
`default_nettype none

// Channel    | Handshake        | Payload                 | Notes
// -----------+------------------+-------------------------+-------------------------------
// request    | start, busy      | request (op, task_id)   | item taken when start && !busy
// result     | done             | result (five fields)    | one cycle only, cannot be held
//
// An item runs through a short sequence: one check step, an optional queue
// read and dispatch, then a report step. The result strobe is registered from
// the report step. An item that dispatches a task from the ready queue also
// passes through the read and dispatch steps; the registered read of the
// queue memory is why the dispatch is a step of its own after the read.
// A new item may be accepted in the very cycle in which the result is shown.
// Reset is synchronous and active high; it leaves every task stopped bar the
// main task, which runs, and an empty queue. No clearing pass is needed.
// The receiver cannot stall, so busy depends only on the work in flight.

module fifo_task_ready_queue (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               start,
  input  wire ftrq_pkg::request_t request,
  output      logic               busy,
  output      logic               done,
  output      ftrq_pkg::result_t  result
);

  // Command and status groups between the sequencer and the datapath.
  ftrq_pkg::ftrq_cmd_t  cmd;
  ftrq_pkg::ftrq_stat_t stat;

  // The sequencer walks each item through its steps and decides, from the
  // status it reads, which table and queue updates the datapath performs.
  ftrq_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .stat  (stat),
    .cmd   (cmd),
    .busy  (busy),
    .done  (done)
  );

  // The datapath holds the task status table, the ring queue of task
  // numbers in its memory, the running task, the waiting flag and the
  // result register.
  ftrq_datapath u_datapath (
    .clk     (clk),
    .rst     (rst),
    .request (request),
    .cmd     (cmd),
    .stat    (stat),
    .result  (result)
  );

endmodule

`default_nettype wire
